// ===== design/assert_macros.svh =====
// assertion helpers for the hash core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst, cond) \
    label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/sha512_pkg.sv =====
`timescale 1ns / 1ps
package sha512_pkg;

    localparam int RoundCount = 80;

    // source of a word pushed into the block buffer
    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_PADDED,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } word_src_t;

    typedef struct packed {
        logic      push;
        word_src_t src;
        logic      add8;
        logic      set_total;
        logic      load_wv;
        logic      round;
        logic [6:0] rnd;
        logic      finish;
        logic      restart;
        logic [2:0] out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] word_count;
    } dp_status_t;

    function automatic logic [63:0] round_k(input logic [6:0] r);
        logic [63:0] k;
        case (r)
            7'd0:  k = 64'h428A2F98D728AE22;  7'd1:  k = 64'h7137449123EF65CD;
            7'd2:  k = 64'hB5C0FBCFEC4D3B2F;  7'd3:  k = 64'hE9B5DBA58189DBBC;
            7'd4:  k = 64'h3956C25BF348B538;  7'd5:  k = 64'h59F111F1B605D019;
            7'd6:  k = 64'h923F82A4AF194F9B;  7'd7:  k = 64'hAB1C5ED5DA6D8118;
            7'd8:  k = 64'hD807AA98A3030242;  7'd9:  k = 64'h12835B0145706FBE;
            7'd10: k = 64'h243185BE4EE4B28C;  7'd11: k = 64'h550C7DC3D5FFB4E2;
            7'd12: k = 64'h72BE5D74F27B896F;  7'd13: k = 64'h80DEB1FE3B1696B1;
            7'd14: k = 64'h9BDC06A725C71235;  7'd15: k = 64'hC19BF174CF692694;
            7'd16: k = 64'hE49B69C19EF14AD2;  7'd17: k = 64'hEFBE4786384F25E3;
            7'd18: k = 64'h0FC19DC68B8CD5B5;  7'd19: k = 64'h240CA1CC77AC9C65;
            7'd20: k = 64'h2DE92C6F592B0275;  7'd21: k = 64'h4A7484AA6EA6E483;
            7'd22: k = 64'h5CB0A9DCBD41FBD4;  7'd23: k = 64'h76F988DA831153B5;
            7'd24: k = 64'h983E5152EE66DFAB;  7'd25: k = 64'hA831C66D2DB43210;
            7'd26: k = 64'hB00327C898FB213F;  7'd27: k = 64'hBF597FC7BEEF0EE4;
            7'd28: k = 64'hC6E00BF33DA88FC2;  7'd29: k = 64'hD5A79147930AA725;
            7'd30: k = 64'h06CA6351E003826F;  7'd31: k = 64'h142929670A0E6E70;
            7'd32: k = 64'h27B70A8546D22FFC;  7'd33: k = 64'h2E1B21385C26C926;
            7'd34: k = 64'h4D2C6DFC5AC42AED;  7'd35: k = 64'h53380D139D95B3DF;
            7'd36: k = 64'h650A73548BAF63DE;  7'd37: k = 64'h766A0ABB3C77B2A8;
            7'd38: k = 64'h81C2C92E47EDAEE6;  7'd39: k = 64'h92722C851482353B;
            7'd40: k = 64'hA2BFE8A14CF10364;  7'd41: k = 64'hA81A664BBC423001;
            7'd42: k = 64'hC24B8B70D0F89791;  7'd43: k = 64'hC76C51A30654BE30;
            7'd44: k = 64'hD192E819D6EF5218;  7'd45: k = 64'hD69906245565A910;
            7'd46: k = 64'hF40E35855771202A;  7'd47: k = 64'h106AA07032BBD1B8;
            7'd48: k = 64'h19A4C116B8D2D0C8;  7'd49: k = 64'h1E376C085141AB53;
            7'd50: k = 64'h2748774CDF8EEB99;  7'd51: k = 64'h34B0BCB5E19B48A8;
            7'd52: k = 64'h391C0CB3C5C95A63;  7'd53: k = 64'h4ED8AA4AE3418ACB;
            7'd54: k = 64'h5B9CCA4F7763E373;  7'd55: k = 64'h682E6FF3D6B2B8A3;
            7'd56: k = 64'h748F82EE5DEFB2FC;  7'd57: k = 64'h78A5636F43172F60;
            7'd58: k = 64'h84C87814A1F0AB72;  7'd59: k = 64'h8CC702081A6439EC;
            7'd60: k = 64'h90BEFFFA23631E28;  7'd61: k = 64'hA4506CEBDE82BDE9;
            7'd62: k = 64'hBEF9A3F7B2C67915;  7'd63: k = 64'hC67178F2E372532B;
            7'd64: k = 64'hCA273ECEEA26619C;  7'd65: k = 64'hD186B8C721C0C207;
            7'd66: k = 64'hEADA7DD6CDE0EB1E;  7'd67: k = 64'hF57D4F7FEE6ED178;
            7'd68: k = 64'h06F067AA72176FBA;  7'd69: k = 64'h0A637DC5A2C898A6;
            7'd70: k = 64'h113F9804BEF90DAE;  7'd71: k = 64'h1B710B35131C471B;
            7'd72: k = 64'h28DB77F523047D84;  7'd73: k = 64'h32CAAB7B40C72493;
            7'd74: k = 64'h3C9EBE0A15C9BEBC;  7'd75: k = 64'h431D67C49C100D4C;
            7'd76: k = 64'h4CC5D4BECB3E42B6;  7'd77: k = 64'h597F299CFC657E2A;
            7'd78: k = 64'h5FCB6FAB3AD6FAEC;  7'd79: k = 64'h6C44198C4A475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    // initial chaining value, unused variant code falls back to full sha-512
    function automatic logic [63:0] init_val(input logic [1:0] v, input logic [2:0] i);
        logic [63:0] r;
        logic [5:0]  sel;
        sel = {1'b0, v, i};
        case (sel)
            6'd8:  r = 64'h8C3D37C819544DA2;  6'd9:  r = 64'h73E1996689DCD4D6;
            6'd10: r = 64'h1DFAB7AE32FF9C82;  6'd11: r = 64'h679DD514582F9FCF;
            6'd12: r = 64'h0F6D2B697BD44DA8;  6'd13: r = 64'h77E36F7304C48942;
            6'd14: r = 64'h3F9D85A86A1D36C8;  6'd15: r = 64'h1112E6AD91D692A1;
            6'd16: r = 64'h22312194FC2BF72C;  6'd17: r = 64'h9F555FA3C84C64C2;
            6'd18: r = 64'h2393B86B6F53B151;  6'd19: r = 64'h963877195940EABD;
            6'd20: r = 64'h96283EE2A88EFFE3;  6'd21: r = 64'hBE5E1E2553863992;
            6'd22: r = 64'h2B0199FC2C85B8AA;  6'd23: r = 64'h0EB72DDC81C52CA2;
            default: begin
                case (i)
                    3'd0: r = 64'h6A09E667F3BCC908;
                    3'd1: r = 64'hBB67AE8584CAA73B;
                    3'd2: r = 64'h3C6EF372FE94F82B;
                    3'd3: r = 64'hA54FF53A5F1D36F1;
                    3'd4: r = 64'h510E527FADE682D1;
                    3'd5: r = 64'h9B05688C2B3E6C1F;
                    3'd6: r = 64'h1F83D9ABFB41BD6B;
                    default: r = 64'h5BE0CD19137E2179;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/sha512_datapath.sv =====
`timescale 1ns / 1ps
module sha512_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha512_pkg::dp_cmd_t   cmd,
    input  logic [1:0]            variant,
    input  logic [63:0]           msg_word,
    input  logic [3:0]            valid_bytes,
    output sha512_pkg::dp_status_t status,
    output logic [63:0]           digest_word
);
    import sha512_pkg::*;

    logic [63:0] hash_reg  [8];
    logic [63:0] wv_reg    [8];
    logic [63:0] sched_reg [16];
    logic [3:0]  wc_reg;
    logic [63:0] bc_reg;

    logic [2:0]  nv;
    logic        nv_full;
    logic [63:0] padded;
    logic [63:0] push_val;
    logic [63:0] w_new;
    logic [63:0] wr;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] e;
    logic [63:0] a;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    assign nv_full = valid_bytes[3];
    assign nv      = valid_bytes[2:0];

    // keep the valid leading bytes, then the 0x80 marker, then zeros
    always_comb begin
        padded = '0;
        for (int b = 0; b < 8; b++) begin
            if (3'(b) < nv) begin
                padded[63 - 8*b -: 8] = msg_word[63 - 8*b -: 8];
            end else if (3'(b) == nv) begin
                padded[63 - 8*b -: 8] = 8'h80;
            end
        end
    end

    always_comb begin
        case (cmd.src)
            SRC_INPUT:  push_val = msg_word;
            SRC_PADDED: push_val = padded;
            SRC_PAD80:  push_val = 64'h8000000000000000;
            SRC_LEN_HI: push_val = {61'd0, bc_reg[63:61]};
            SRC_LEN_LO: push_val = {bc_reg[60:0], 3'b000};
            default:    push_val = '0;
        endcase
    end

    // message schedule and one round
    assign w_new = (rotr(sched_reg[14], 19) ^ rotr(sched_reg[14], 61) ^ (sched_reg[14] >> 6))
                 + sched_reg[9]
                 + (rotr(sched_reg[1], 1) ^ rotr(sched_reg[1], 8) ^ (sched_reg[1] >> 7))
                 + sched_reg[0];
    assign wr = (cmd.rnd < 7'd16) ? sched_reg[0] : w_new;
    assign e  = wv_reg[4];
    assign a  = wv_reg[0];
    assign t1 = wv_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
              + ((e & wv_reg[5]) ^ (~e & wv_reg[6])) + round_k(cmd.rnd) + wr;
    assign t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
              + ((a & wv_reg[1]) ^ (a & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));

    // block buffer as a shift line
    always_ff @(posedge aclk) begin
        if (cmd.push || cmd.round) begin
            for (int i = 0; i < 15; i++) sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= cmd.push ? push_val : wr;
        end
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (cmd.load_wv) begin
            for (int i = 0; i < 8; i++) wv_reg[i] <= hash_reg[i];
        end else if (cmd.round) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    // chaining state and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_val(2'd0, 3'(i));
            wc_reg <= '0;
            bc_reg <= '0;
        end else if (cmd.restart) begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_val(variant, 3'(i));
            wc_reg <= '0;
            bc_reg <= '0;
        end else begin
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + wv_reg[i];
            end
            if (cmd.push) wc_reg <= wc_reg + 4'd1;
            if (cmd.add8) begin
                bc_reg <= bc_reg + 64'd8;
            end else if (cmd.set_total) begin
                bc_reg <= bc_reg + (nv_full ? 64'd8 : {61'd0, nv});
            end
        end
    end

    assign status.word_count = wc_reg;
    assign digest_word       = hash_reg[cmd.out_idx];

endmodule

// ===== design/sha512_ctrl.sv =====
`timescale 1ns / 1ps
module sha512_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_last,
    input  logic                   s_full,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  sha512_pkg::dp_status_t status,
    output sha512_pkg::dp_cmd_t    cmd
);
    import sha512_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FINISH, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       need80_reg, need80_next;
    logic       len_reg, len_next;
    logic       wc_top;

    assign wc_top   = (status.word_count == 4'd15);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        cmd         = '0;
        cmd.src     = SRC_ZERO;
        cmd.rnd     = rnd_reg;
        cmd.out_idx = idx_reg;
        state_next  = state_reg;
        ret_next    = ret_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        need80_next = need80_reg;
        len_next    = len_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.push = 1'b1;
                    if (!s_last) begin
                        cmd.src  = SRC_INPUT;
                        cmd.add8 = 1'b1;
                        if (wc_top) begin
                            ret_next   = ST_IDLE;
                            state_next = ST_LOAD;
                        end
                    end else begin
                        cmd.src       = s_full ? SRC_INPUT : SRC_PADDED;
                        cmd.set_total = 1'b1;
                        need80_next   = s_full;
                        ret_next      = ST_PAD;
                        state_next    = wc_top ? ST_LOAD : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // marker word if the last word was full, zero fill, then the two length words
                cmd.push = 1'b1;
                if (need80_reg) begin
                    cmd.src     = SRC_PAD80;
                    need80_next = 1'b0;
                end else if (status.word_count == 4'd14) begin
                    cmd.src  = SRC_LEN_HI;
                    len_next = 1'b1;
                end else if (wc_top && len_reg) begin
                    cmd.src  = SRC_LEN_LO;
                    len_next = 1'b0;
                end else begin
                    cmd.src = SRC_ZERO;
                end
                if (wc_top) begin
                    ret_next   = (len_reg && !need80_reg) ? ST_OUT : ST_PAD;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_wv = 1'b1;
                rnd_next    = '0;
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (rnd_reg == 7'(RoundCount - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ret_reg;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (idx_reg == 3'd7) begin
                        cmd.restart = 1'b1;
                        idx_next    = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            need80_reg <= 1'b0;
            len_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            need80_reg <= need80_next;
            len_reg    <= len_next;
        end
    end

endmodule

// ===== design/sha512_hash_core.sv =====
`timescale 1ns / 1ps
// sha-512 core: a word that does not fill the block is taken with no stall
// a full block adds the load, 80 rounds at one per cycle, then the chaining add
// last word: padding words one per cycle between compressions, one or two compressions, 8 digest items
// sustained rate set by the single shared round unit, as input stalls while a block compresses
// reset is synchronous active low: sha-512 initial values, counts cleared
module sha512_hash_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // msg_word[63:0], valid_bytes[67:64], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic [2:0]  m_tuser,   // digest_index[2:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sha512_pkg::*;

    dp_cmd_t    ctrl_cmd;
    dp_cmd_t    dp_cmd;
    dp_status_t status;
    logic [1:0] variant_reg;
    logic       cfg_we;
    logic [1:0] variant_use;

    // configuration register
    assign pready      = 1'b1;
    assign cfg_we      = psel && penable && pwrite && !paddr[2];
    assign variant_use = cfg_we ? pwdata[1:0] : variant_reg;
    assign prdata      = paddr[2] ? 32'd0 : {30'd0, variant_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= 2'd0;
        end else if (cfg_we) begin
            variant_reg <= pwdata[1:0];
        end
    end

    // a variant write restarts the message
    always_comb begin
        dp_cmd         = ctrl_cmd;
        dp_cmd.restart = ctrl_cmd.restart || cfg_we;
    end

    sha512_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_last   (s_tlast),
        .s_full   (s_tdata[67]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (ctrl_cmd)
    );

    sha512_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (dp_cmd),
        .variant     (variant_use),
        .msg_word    (s_tdata[63:0]),
        .valid_bytes (s_tdata[67:64]),
        .status      (status),
        .digest_word (m_tdata)
    );

    assign m_tuser = ctrl_cmd.out_idx;
    assign m_tlast = (ctrl_cmd.out_idx == 3'd7);

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_no_overlap, aclk, !aresetn, s_tready && m_tvalid)
    `ASSERT_IMPLIES(a_restart_on_last, aclk, !aresetn, m_tvalid && m_tready && m_tlast, ctrl_cmd.restart)
    `ASSERT_NEXT(a_idle_after_digest, aclk, !aresetn, m_tvalid && m_tready && m_tlast, s_tready)

endmodule
